/* src/frt_pkg.sv */
package frt_pkg;

  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int TimeW      = 48;
  localparam int IdW        = 16;
  localparam int OffW       = 16;
  localparam int LenW       = 16;
  localparam int RegW       = 32;
  localparam int TotW       = 17;
  // slot memory word: more flag, length, deadline
  localparam int MemW       = 1 + LenW + TimeW;

  localparam logic [1:0] StHeld      = 2'd0;
  localparam logic [1:0] StDelivered = 2'd1;
  localparam logic [1:0] StDropProto = 2'd2;
  localparam logic [1:0] StDropFull  = 2'd3;

  localparam logic [1:0] RegTimeout  = 2'd0;
  localparam logic [1:0] RegInterval = 2'd1;

  localparam logic [RegW-1:0] TimeoutRst  = 32'd30000;
  localparam logic [RegW-1:0] IntervalRst = 32'd1000;

  typedef struct packed {
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
    logic            clr_en;
    logic [IdxW-1:0] clr_idx;
    logic            rel_en;
  } cam_ctrl_t;

  typedef struct packed {
    logic            free_found;
    logic [IdxW-1:0] free_idx;
    logic            hit_found;
    logic [IdxW-1:0] hit_idx;
  } cam_stat_t;

  // protocol number to output port, bit 3 flags an unknown protocol
  function automatic logic [3:0] port_of(input logic [7:0] proto);
    logic [3:0] r;
    case (proto)
      8'd1:    r = 4'd0;
      8'd2:    r = 4'd1;
      8'd4:    r = 4'd2;
      8'd6:    r = 4'd3;
      8'd17:   r = 4'd4;
      8'd46:   r = 4'd5;
      default: r = 4'b1000;
    endcase
    return r;
  endfunction

endpackage

/* src/frt_slot_mem.sv */
module frt_slot_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [frt_pkg::IdxW-1:0]    waddr_i,
  input  logic [frt_pkg::MemW-1:0]    wdata_i,
  input  logic [frt_pkg::IdxW-1:0]    raddr_i,
  output logic [frt_pkg::MemW-1:0]    rdata_o
);
  import frt_pkg::*;

  logic [MemW-1:0] mem_q [TableDepth];

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/frt_cam.sv */
module frt_cam (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  frt_pkg::cam_ctrl_t        ctrl_i,
  input  logic [frt_pkg::IdW-1:0]   wr_id_i,
  input  logic [frt_pkg::OffW-1:0]  wr_off_i,
  input  logic [frt_pkg::IdW-1:0]   key_id_i,
  input  logic [frt_pkg::TotW-1:0]  key_off_i,
  output frt_pkg::cam_stat_t        stat_o
);
  import frt_pkg::*;

  logic [TableDepth-1:0] used_q;
  logic [IdW-1:0]        id_q  [TableDepth];
  logic [OffW-1:0]       off_q [TableDepth];
  logic [TableDepth-1:0] id_eq;
  logic [TableDepth-1:0] hit;

  // per-slot compare against the key
  always_comb begin
    for (int i = 0; i < TableDepth; i++) begin
      id_eq[i] = used_q[i] && (id_q[i] == key_id_i);
      hit[i]   = id_eq[i] && !key_off_i[TotW-1] && (off_q[i] == key_off_i[OffW-1:0]);
    end
  end

  // lowest free slot and lowest matching slot
  always_comb begin
    stat_o = '0;
    for (int i = TableDepth - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        stat_o.free_found = 1'b1;
        stat_o.free_idx   = IdxW'(i);
      end
      if (hit[i]) begin
        stat_o.hit_found = 1'b1;
        stat_o.hit_idx   = IdxW'(i);
      end
    end
  end

  // occupancy bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      if (ctrl_i.wr_en) begin
        used_q[ctrl_i.wr_idx] <= 1'b1;
      end
      if (ctrl_i.clr_en) begin
        used_q[ctrl_i.clr_idx] <= 1'b0;
      end
      if (ctrl_i.rel_en) begin
        used_q <= used_q & ~id_eq;
      end
    end
  end

  // key storage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      id_q[ctrl_i.wr_idx]  <= wr_id_i;
      off_q[ctrl_i.wr_idx] <= wr_off_i;
    end
  end

endmodule

/* src/ipv4_fragment_reassembly_tracker.sv */
// flow: an unfragmented datagram or a full table goes from decide straight to output; a
//   timeout sweep runs first when due (one slot memory read per cycle), and a stored
//   fragment walks the table one completeness step at a time; one item at a time, a new
//   one taken only back in idle, sweep and walk paced by the single slot memory read port
// reset: table empty, timeout 30000, interval 1000, last sweep time zero
module ipv4_fragment_reassembly_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_index_i,
  input  logic [frt_pkg::RegW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [frt_pkg::TimeW-1:0]   now_i,
  input  logic [frt_pkg::IdW-1:0]     datagram_id_i,
  input  logic [frt_pkg::OffW-1:0]    frag_offset_i,
  input  logic                        more_frags_i,
  input  logic [frt_pkg::LenW-1:0]    payload_bytes_i,
  input  logic [7:0]                  proto_number_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [2:0]                  port_select_o,
  output logic [frt_pkg::IdW-1:0]     out_id_o,
  output logic [frt_pkg::TotW-1:0]    total_bytes_o
);
  import frt_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SSweep  = 3'd1;
  localparam logic [2:0] SDecide = 3'd2;
  localparam logic [2:0] SWalk   = 3'd3;
  localparam logic [2:0] SWalkRd = 3'd4;
  localparam logic [2:0] SOut    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [RegW-1:0]  timeout_q, interval_q;
  logic [TimeW-1:0] last_q, last_d;
  logic [TimeW-1:0] now_q;
  logic [IdW-1:0]   id_q;
  logic [OffW-1:0]  off_q;
  logic             more_q;
  logic [LenW-1:0]  len_q;
  logic [7:0]       proto_q;
  logic [IdxW:0]    cnt_q, cnt_d;
  logic             sw_pend_q, sw_pend_d;
  logic [IdxW-1:0]  sw_idx_q, sw_idx_d;
  logic [IdxW-1:0]  step_q, step_d;
  logic [TotW-1:0]  next_q, next_d;
  logic [1:0]       res_st_q, res_st_d;
  logic [TotW-1:0]  res_tot_q, res_tot_d;
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [2:0]       port_q;
  logic [IdW-1:0]   out_id_q;
  logic [TotW-1:0]  total_q;

  cam_ctrl_t        cam_ctrl;
  cam_stat_t        cam_stat;
  logic             mem_we;
  logic [MemW-1:0]  mem_wdata, mem_rdata;
  logic [IdxW-1:0]  mem_raddr;
  logic             rd_more;
  logic [LenW-1:0]  rd_len;
  logic [TimeW-1:0] rd_dl;
  logic [TimeW:0]   dl_sum;
  logic [TimeW-1:0] deadline;
  logic [TotW-1:0]  walk_sum;
  logic             in_fire;
  logic             sweep_due;
  logic [3:0]       port_code;

  assign in_ready_o = (state_q == SIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign {rd_more, rd_len, rd_dl} = mem_rdata;

  // sweep trigger, deadline and walk adders
  assign sweep_due = ({1'b0, now_i} >= ({1'b0, last_q} + {{(TimeW + 1 - RegW){1'b0}}, interval_q}));
  assign dl_sum    = {1'b0, now_q} + {{(TimeW + 1 - RegW){1'b0}}, timeout_q};
  assign deadline  = dl_sum[TimeW] ? {TimeW{1'b1}} : dl_sum[TimeW-1:0];
  assign walk_sum  = next_q + {{(TotW - LenW){1'b0}}, rd_len};
  assign port_code = port_of(proto_q);
  assign mem_wdata = {more_q, len_q, deadline};

  frt_cam u_cam (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cam_ctrl),
    .wr_id_i   (id_q),
    .wr_off_i  (off_q),
    .key_id_i  (id_q),
    .key_off_i (next_q),
    .stat_o    (cam_stat)
  );

  frt_slot_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cam_stat.free_idx),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // sequencer
  always_comb begin
    state_d   = state_q;
    last_d    = last_q;
    cnt_d     = cnt_q;
    sw_pend_d = 1'b0;
    sw_idx_d  = sw_idx_q;
    step_d    = step_q;
    next_d    = next_q;
    res_st_d  = res_st_q;
    res_tot_d = res_tot_q;
    cam_ctrl  = '0;
    mem_we    = 1'b0;
    mem_raddr = cam_stat.hit_idx;
    case (state_q)
      SIdle: begin
        if (in_fire) begin
          cnt_d = '0;
          if (sweep_due) begin
            last_d  = now_i;
            state_d = SSweep;
          end else begin
            state_d = SDecide;
          end
        end
      end
      SSweep: begin
        // evict the slot read last cycle if past its deadline
        if (sw_pend_q && (now_q > rd_dl)) begin
          cam_ctrl.clr_en  = 1'b1;
          cam_ctrl.clr_idx = sw_idx_q;
        end
        mem_raddr = cnt_q[IdxW-1:0];
        if (cnt_q != (IdxW + 1)'(TableDepth)) begin
          sw_pend_d = 1'b1;
          sw_idx_d  = cnt_q[IdxW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end else begin
          state_d = SDecide;
        end
      end
      SDecide: begin
        res_tot_d = {{(TotW - LenW){1'b0}}, len_q};
        if ((off_q == '0) && !more_q) begin
          res_st_d = StDelivered;
          state_d  = SOut;
        end else if (!cam_stat.free_found) begin
          res_st_d = StDropFull;
          state_d  = SOut;
        end else begin
          cam_ctrl.wr_en  = 1'b1;
          cam_ctrl.wr_idx = cam_stat.free_idx;
          mem_we          = 1'b1;
          next_d          = '0;
          step_d          = '0;
          state_d         = SWalk;
        end
      end
      SWalk: begin
        if (cam_stat.hit_found) begin
          state_d = SWalkRd;
        end else begin
          res_st_d = StHeld;
          state_d  = SOut;
        end
      end
      SWalkRd: begin
        if (!rd_more) begin
          cam_ctrl.rel_en = 1'b1;
          res_st_d        = StDelivered;
          res_tot_d       = walk_sum;
          state_d         = SOut;
        end else if (walk_sum[TotW-1] || (step_q == IdxW'(TableDepth - 1))) begin
          res_st_d = StHeld;
          state_d  = SOut;
        end else begin
          next_d  = walk_sum;
          step_d  = step_q + 1'b1;
          state_d = SWalk;
        end
      end
      SOut: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SIdle;
      last_q     <= '0;
      timeout_q  <= TimeoutRst;
      interval_q <= IntervalRst;
      cnt_q      <= '0;
      sw_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      last_q    <= last_d;
      cnt_q     <= cnt_d;
      sw_pend_q <= sw_pend_d;
      if (cfg_we_i && (cfg_index_i == RegTimeout)) begin
        timeout_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == RegInterval)) begin
        interval_q <= cfg_data_i;
      end
      if ((state_q == SOut) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    sw_idx_q  <= sw_idx_d;
    step_q    <= step_d;
    next_q    <= next_d;
    res_st_q  <= res_st_d;
    res_tot_q <= res_tot_d;
    if (in_fire) begin
      now_q   <= now_i;
      id_q    <= datagram_id_i;
      off_q   <= frag_offset_i;
      more_q  <= more_frags_i;
      len_q   <= payload_bytes_i;
      proto_q <= proto_number_i;
    end
    if ((state_q == SOut) && (!out_valid_q || out_ready_i)) begin
      out_id_q <= id_q;
      if ((res_st_q == StDelivered) && port_code[3]) begin
        status_q <= StDropProto;
        port_q   <= '0;
        total_q  <= '0;
      end else if (res_st_q == StDelivered) begin
        status_q <= StDelivered;
        port_q   <= port_code[2:0];
        total_q  <= res_tot_q;
      end else begin
        status_q <= res_st_q;
        port_q   <= '0;
        total_q  <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign port_select_o = port_q;
  assign out_id_o      = out_id_q;
  assign total_bytes_o = total_q;

  // a fragment is only stored into a free slot
  a_store_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cam_ctrl.wr_en |-> cam_stat.free_found)
    else $error("fragment stored without a free slot");

  // after a release no slot of that datagram is left
  a_release_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cam_ctrl.rel_en) |-> !cam_stat.hit_found)
    else $error("slot left after release");

  // only a delivered result carries a port and a byte count
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != StDelivered)) |-> ((port_select_o == '0) && (total_bytes_o == '0)))
    else $error("port or total set on a non-delivered result");

  // the sweep counter never runs past the table depth
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SSweep) |-> (cnt_q <= (IdxW + 1)'(TableDepth)))
    else $error("sweep counter past table depth");

endmodule
